>>> sv/sbm_pkg.sv
// Shared constants, types and command structs for the spectrum bar meter.
package sbm_pkg;

  localparam int NUM_BAND   = 4;
  localparam int BIN_COUNT  = 1024;
  localparam int HEIGHT_MAX = 32;

  localparam int MAG_W  = 24;
  localparam int IDX_W  = 12;
  localparam int BAND_W = 2;
  localparam int LVL_W  = 8;
  localparam int HGT_W  = 16;
  localparam int LOG_W  = 21;   // Q5.16
  localparam int Y_W    = 31;   // Q1.30 mantissa
  localparam int SCL_W  = 40;
  localparam int NUM_W  = 32;
  localparam int CNT_W  = 6;

  localparam logic [18:0] DB_SCALE_Q16 = 19'd394566;
  localparam logic [IDX_W:0] BIN_LIMIT = (IDX_W+1)'(BIN_COUNT);
  localparam logic [NUM_W-1:0] TGT_SCALE = NUM_W'(HEIGHT_MAX * 256);
  localparam logic [CNT_W-1:0] LOG_LAST = CNT_W'(17);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W);

  localparam logic [23:0] RST_NOISE_FLOOR = 24'd16;
  localparam logic [15:0] RST_GAIN_DECAY  = 16'd65208;
  localparam logic [15:0] RST_BAR_FALL    = 16'd128;
  localparam logic [7:0]  RST_HOLD_FRAMES = 8'd30;
  localparam logic [15:0] RST_HOLD_FALL   = 16'd64;
  localparam logic [15:0] RST_DB_FLOOR    = 16'hC400;
  localparam logic [47:0] RST_LOW_BINS    = 48'd19174294339585;
  localparam logic [47:0] RST_HIGH_BINS   = 48'd63776338853899;

  typedef enum logic [2:0] {
    CFG_NOISE_FLOOR = 3'd0,
    CFG_GAIN_DECAY  = 3'd1,
    CFG_BAR_FALL    = 3'd2,
    CFG_HOLD_FRAMES = 3'd3,
    CFG_HOLD_FALL   = 3'd4,
    CFG_DB_FLOOR    = 3'd5,
    CFG_LOW_BINS    = 3'd6,
    CFG_HIGH_BINS   = 3'd7
  } cfg_idx_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_GAIN  = 8'b0000_0010,
    ST_DECAY = 8'b0000_0100,
    ST_LOGG  = 8'b0000_1000,
    ST_LOGE  = 8'b0001_0000,
    ST_SCALE = 8'b0010_0000,
    ST_DIV   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic              in_rdy;
    logic              gain_cmp;
    logic              gain_dec;
    logic              log_ld;
    logic              log_sel_gain;
    logic              log_step;
    logic              lg_latch;
    logic              scale;
    logic              div_ld;
    logic              div_step;
    logic              emit;
    logic              clear;
    logic [BAND_W-1:0] band;
  } cmd_t;

  typedef struct packed {
    logic last_fire;
    logic out_free;
  } sts_t;

endpackage

>>> sv/sbm_ctrl.sv
// Frame-end sequencer: gain update, log2, scaling, divide and per-band emit.
module sbm_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  sbm_pkg::sts_t sts,
  output sbm_pkg::cmd_t cmd
);
  import sbm_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BAND_W-1:0] band_r, band_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      band_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      band_r  <= band_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    band_nxt  = band_r;
    cmd       = '0;
    cmd.band  = band_r;
    case (state_r)
      ST_IDLE: begin
        cmd.in_rdy = 1'b1;
        if (sts.last_fire) begin
          state_nxt = ST_GAIN;
        end
      end
      ST_GAIN: begin
        cmd.gain_cmp = 1'b1;
        state_nxt    = ST_DECAY;
      end
      ST_DECAY: begin
        cmd.gain_dec = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_LOGG;
      end
      ST_LOGG: begin
        cmd.log_sel_gain = 1'b1;
        cmd.log_ld       = (cnt_r == '0);
        cmd.log_step     = (cnt_r != '0) && (cnt_r != LOG_LAST);
        cnt_nxt          = cnt_r + CNT_W'(1);
        if (cnt_r == LOG_LAST) begin
          cmd.lg_latch = 1'b1;
          cnt_nxt      = '0;
          band_nxt     = '0;
          state_nxt    = ST_LOGE;
        end
      end
      ST_LOGE: begin
        cmd.log_ld   = (cnt_r == '0);
        cmd.log_step = (cnt_r != '0) && (cnt_r != LOG_LAST);
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == LOG_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_ld   = (cnt_r == '0);
        cmd.div_step = (cnt_r != '0);
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (band_r == BAND_W'(NUM_BAND - 1)) begin
            cmd.clear = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            band_nxt  = band_r + BAND_W'(1);
            state_nxt = ST_LOGE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/sbm_datapath.sv
// Datapath: config registers, band maxima, gain, log2 unit, divider, bar state.
module sbm_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  sbm_pkg::cmd_t                cmd,
  output sbm_pkg::sts_t                sts,
  input  logic                         cfg_valid,
  input  logic [2:0]                   cfg_index,
  input  logic [47:0]                  cfg_data,
  input  logic                         in_valid,
  input  logic [sbm_pkg::MAG_W-1:0]    in_magnitude,
  input  logic                         in_last_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbm_pkg::BAND_W-1:0]   out_band,
  output logic [sbm_pkg::LVL_W-1:0]    out_bar_level,
  output logic [sbm_pkg::LVL_W-1:0]    out_peak_level,
  output logic                         out_last_band
);
  import sbm_pkg::*;

  logic [23:0] nf_r;
  logic [15:0] decay_r, bar_fall_r, hold_fall_r, dbf_r;
  logic [7:0]  hold_frames_r;
  logic [47:0] low_r, high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r          <= RST_NOISE_FLOOR;
      decay_r       <= RST_GAIN_DECAY;
      bar_fall_r    <= RST_BAR_FALL;
      hold_frames_r <= RST_HOLD_FRAMES;
      hold_fall_r   <= RST_HOLD_FALL;
      dbf_r         <= RST_DB_FLOOR;
      low_r         <= RST_LOW_BINS;
      high_r        <= RST_HIGH_BINS;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NOISE_FLOOR: nf_r          <= cfg_data[23:0];
        CFG_GAIN_DECAY:  decay_r       <= cfg_data[15:0];
        CFG_BAR_FALL:    bar_fall_r    <= cfg_data[15:0];
        CFG_HOLD_FRAMES: hold_frames_r <= cfg_data[7:0];
        CFG_HOLD_FALL:   hold_fall_r   <= cfg_data[15:0];
        CFG_DB_FLOOR:    dbf_r         <= cfg_data[15:0];
        CFG_LOW_BINS:    low_r         <= cfg_data;
        CFG_HIGH_BINS:   high_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // bin accumulation
  logic             in_fire;
  logic [IDX_W-1:0] idx_r;
  logic [MAG_W-1:0] bmax_r [NUM_BAND];
  logic [MAG_W-1:0] energy [NUM_BAND];
  logic [MAG_W-1:0] loudest;

  assign in_fire       = in_valid && cmd.in_rdy;
  assign sts.last_fire = in_fire && in_last_bin;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      idx_r <= '0;
      for (int b = 0; b < NUM_BAND; b++) bmax_r[b] <= '0;
    end else if (in_fire) begin
      if ({1'b0, idx_r} < BIN_LIMIT) begin
        for (int b = 0; b < NUM_BAND; b++) begin
          if (idx_r >= low_r[12*b +: 12] && idx_r <= high_r[12*b +: 12] &&
              in_magnitude > bmax_r[b])
            bmax_r[b] <= in_magnitude;
        end
      end
      if (!in_last_bin && idx_r != '1) idx_r <= idx_r + IDX_W'(1);
    end
  end

  always_comb begin
    loudest = '0;
    for (int b = 0; b < NUM_BAND; b++) begin
      energy[b] = (bmax_r[b] < nf_r) ? '0 : bmax_r[b];
      if (energy[b] > loudest) loudest = energy[b];
    end
  end

  // auto-gain peak
  logic [MAG_W-1:0] gain_r, gdec;
  logic [39:0]      gprod_r;
  logic             dec_pend_r;

  always_comb begin
    gdec = gprod_r[39:16];
    if (gdec < nf_r) gdec = nf_r;
    if (gdec == '0) gdec = MAG_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r     <= MAG_W'(1);
      dec_pend_r <= 1'b0;
    end else if (cmd.gain_cmp) begin
      dec_pend_r <= !(loudest > gain_r);
      if (loudest > gain_r) gain_r <= loudest;
    end else if (cmd.gain_dec && dec_pend_r) begin
      gain_r <= gdec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gain_cmp) gprod_r <= gain_r * decay_r;
  end

  // log2 unit: one squaring per step
  logic [MAG_W-1:0] lx;
  logic [4:0]       lz;
  logic [4:0]       e_r;
  logic [15:0]      frac_r;
  logic [Y_W-1:0]   y_r;
  logic [61:0]      ysq;
  logic [31:0]      ytr;
  logic [LOG_W-1:0] lg_r, lm;

  assign lx = cmd.log_sel_gain ? gain_r : energy[cmd.band];

  always_comb begin
    lz = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (lx[i]) lz = 5'(i);
    end
  end

  assign ysq = y_r * y_r;
  assign ytr = ysq[61:30];
  assign lm  = {e_r, frac_r};

  always_ff @(posedge clk) begin
    if (cmd.log_ld) begin
      e_r    <= lz;
      frac_r <= '0;
      y_r    <= Y_W'({7'd0, lx} << (5'd30 - lz));
    end else if (cmd.log_step) begin
      frac_r <= {frac_r[14:0], ytr[31]};
      y_r    <= ytr[31] ? ytr[31:1] : ytr[30:0];
    end
    if (cmd.lg_latch) lg_r <= lm;
  end

  // dB scale, floor clamp, and target divide
  logic [SCL_W-1:0]  scl_r;
  logic [LOG_W-1:0]  neg;
  logic [SCL_W:0]    rsum;
  logic [16:0]       q17;
  logic signed [16:0] fl, db;
  logic [15:0]       dvs, diff;
  logic [NUM_W-1:0]  num_r;
  logic [15:0]       rem_r;
  logic [16:0]       trial;
  logic              ezero_r;

  assign neg  = (lm >= lg_r) ? '0 : lg_r - lm;
  assign rsum = {1'b0, scl_r} + (SCL_W+1)'(1 << 23);
  assign q17  = rsum[40:24];
  assign fl   = ($signed(dbf_r) < -16'sd1) ? 17'($signed(dbf_r)) : -17'sd1;
  assign dvs  = 16'(-fl);

  always_comb begin
    db = (q17 > 17'd32768) ? -17'sd32768 : -$signed(q17);
    if (db < fl) db = fl;
    diff = 16'(db - fl);
  end

  assign trial = {rem_r, num_r[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.scale) begin
      scl_r   <= neg * DB_SCALE_Q16;
      ezero_r <= (energy[cmd.band] == '0);
    end
    if (cmd.div_ld) begin
      num_r <= NUM_W'(diff) * TGT_SCALE;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (trial >= {1'b0, dvs}) begin
        rem_r <= 16'(trial - {1'b0, dvs});
        num_r <= {num_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= trial[15:0];
        num_r <= {num_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  // bar and peak-hold update
  logic [HGT_W-1:0] bar_r   [NUM_BAND];
  logic [HGT_W-1:0] hold_r  [NUM_BAND];
  logic [7:0]       timer_r [NUM_BAND];
  logic [HGT_W-1:0] target, bar_nxt, hold_nxt, bar_cur, hold_cur;
  logic [7:0]       timer_nxt, timer_cur;
  logic [LVL_W-1:0] bar_lvl, peak_lvl;

  function automatic logic [LVL_W-1:0] round_h(input logic [HGT_W-1:0] h);
    logic [8:0] r;
    r = 9'(({1'b0, h} + 17'd128) >> 8);
    return (r > 9'(HEIGHT_MAX)) ? LVL_W'(HEIGHT_MAX) : r[LVL_W-1:0];
  endfunction

  always_comb begin
    bar_cur   = bar_r[cmd.band];
    hold_cur  = hold_r[cmd.band];
    timer_cur = timer_r[cmd.band];
    target    = ezero_r ? '0 : num_r[HGT_W-1:0];
    if (target > bar_cur) bar_nxt = target;
    else bar_nxt = (bar_cur > bar_fall_r) ? bar_cur - bar_fall_r : '0;
    hold_nxt  = hold_cur;
    timer_nxt = timer_cur;
    if (bar_nxt >= hold_cur) begin
      hold_nxt  = bar_nxt;
      timer_nxt = hold_frames_r;
    end else if (timer_cur != '0) begin
      timer_nxt = timer_cur - 8'd1;
    end else begin
      hold_nxt = (hold_cur > hold_fall_r) ? hold_cur - hold_fall_r : '0;
    end
    bar_lvl  = round_h(bar_nxt);
    peak_lvl = round_h(hold_nxt);
    if (peak_lvl < bar_lvl) peak_lvl = bar_lvl;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int b = 0; b < NUM_BAND; b++) begin
        bar_r[b]   <= '0;
        hold_r[b]  <= '0;
        timer_r[b] <= '0;
      end
    end else if (cmd.emit) begin
      bar_r[cmd.band]   <= bar_nxt;
      hold_r[cmd.band]  <= hold_nxt;
      timer_r[cmd.band] <= timer_nxt;
    end
  end

  // output word register
  logic out_valid_r;

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_band       <= cmd.band;
      out_bar_level  <= bar_lvl;
      out_peak_level <= peak_lvl;
      out_last_band  <= (cmd.band == BAND_W'(NUM_BAND - 1));
    end
  end

endmodule

>>> sv/spectrum_bar_meter_unit.sv
// Spectrum bar meter: per-band max over FFT bins, auto-gain, dB bars with peak hold.
// Bins are taken one per cycle while in_ready is high. A word with last_bin set starts the frame-end
// pass, during which in_ready is low: a gain update (compare, then decay), log2 of
// the gain peak, then per band a log2, a scale step, the divide and an emit, which
// waits while the output register is full and out_ready is low. The log2 unit
// squares out one fraction bit per step, and the divider is a restoring divider.
// Result words leave through an output register, so the next frame's bins are
// accepted while the final band word waits. Configuration writes are always taken.
module spectrum_bar_meter_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [47:0]                  cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [sbm_pkg::MAG_W-1:0]    in_magnitude,
  input  logic                         in_last_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [sbm_pkg::BAND_W-1:0]   out_band,
  output logic [sbm_pkg::LVL_W-1:0]    out_bar_level,
  output logic [sbm_pkg::LVL_W-1:0]    out_peak_level,
  output logic                         out_last_band
);
  import sbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd.in_rdy;

  sbm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  sbm_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_magnitude   (in_magnitude),
    .in_last_bin    (in_last_bin),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_band       (out_band),
    .out_bar_level  (out_bar_level),
    .out_peak_level (out_peak_level),
    .out_last_band  (out_last_band)
  );

endmodule
